// ----- src/dlpg_pkg.sv -----
package dlpg_pkg;

   localparam int COLOR_BITS = 32;

   // request function codes
   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   // controller to datapath commands
   typedef struct packed {
      logic start;     // latch endpoints, color, deltas; seed the divider
      logic step;      // emit current pixel and advance
      logic div_run;   // one divider iteration
      logic finish;    // last iteration: commit increments, issue start response
   } dlpg_cmd_type;

endpackage

// ----- src/dlpg_req_if.sv -----
interface dlpg_req_if #(
   parameter int COORD_BITS = 12
) ();
   logic                           valid;
   logic                           ready;
   logic                           func;
   logic signed [COORD_BITS-1:0]   start_x;
   logic signed [COORD_BITS-1:0]   start_y;
   logic signed [COORD_BITS-1:0]   end_x;
   logic signed [COORD_BITS-1:0]   end_y;
   logic [dlpg_pkg::COLOR_BITS-1:0] line_color;

   modport source (
      output valid, func, start_x, start_y, end_x, end_y, line_color,
      input  ready
   );
   modport sink (
      input  valid, func, start_x, start_y, end_x, end_y, line_color,
      output ready
   );
endinterface

// ----- src/dlpg_rsp_if.sv -----
interface dlpg_rsp_if #(
   parameter int COORD_BITS = 12
) ();
   logic                           valid;
   logic                           ready;
   logic                           pixel_valid;
   logic signed [COORD_BITS-1:0]   pixel_x;
   logic signed [COORD_BITS-1:0]   pixel_y;
   logic [dlpg_pkg::COLOR_BITS-1:0] pixel_color;
   logic                           last_pixel;
   logic [COORD_BITS-1:0]          line_length;

   modport source (
      output valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel, line_length,
      input  ready
   );
   modport sink (
      input  valid, pixel_valid, pixel_x, pixel_y, pixel_color, last_pixel, line_length,
      output ready
   );
endinterface

// ----- src/dlpg_ctrl.sv -----
module dlpg_ctrl #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_func,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dlpg_pkg::dlpg_cmd_type cmd
);
   import dlpg_pkg::*;

   localparam int CNT_BITS = $clog2(FRAC_BITS + 1);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAC_BITS);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_DIV  = 1'b1;

   logic                state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;
   logic                accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.start   = accept && (req_func == FUNC_START);
      cmd.step    = accept && (req_func == FUNC_STEP);
      cmd.div_run = (state_ff == ST_DIV);
      cmd.finish  = (state_ff == ST_DIV) && (cnt_ff == CNT_LAST);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (cmd.start) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cmd.finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.step || cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/dlpg_datapath.sv -----
module dlpg_datapath #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dlpg_pkg::dlpg_cmd_type              cmd,
   input  logic signed [COORD_BITS-1:0]        req_start_x,
   input  logic signed [COORD_BITS-1:0]        req_start_y,
   input  logic signed [COORD_BITS-1:0]        req_end_x,
   input  logic signed [COORD_BITS-1:0]        req_end_y,
   input  logic [dlpg_pkg::COLOR_BITS-1:0]     req_line_color,
   output logic                                rsp_pixel_valid,
   output logic signed [COORD_BITS-1:0]        rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]        rsp_pixel_y,
   output logic [dlpg_pkg::COLOR_BITS-1:0]     rsp_pixel_color,
   output logic                                rsp_last_pixel,
   output logic [COORD_BITS-1:0]               rsp_line_length
);
   import dlpg_pkg::*;

   localparam int PW = COORD_BITS + FRAC_BITS + 2;  // position width
   localparam int SW = FRAC_BITS + 2;               // increment width
   localparam int QW = FRAC_BITS + 1;               // quotient magnitude width
   localparam int RW = COORD_BITS + 1;              // partial remainder width
   localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

   // line state
   logic [PW-1:0]         pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [SW-1:0]         step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic [COORD_BITS-1:0] left_ff, left_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   // divider
   logic [COORD_BITS-1:0] len_ff, len_in;
   logic                  neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [RW-1:0]         rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [QW-1:0]         quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   // response
   logic                  o_valid_ff, o_valid_in, o_last_ff, o_last_in;
   logic [COORD_BITS-1:0] o_x_ff, o_x_in, o_y_ff, o_y_in, o_len_ff, o_len_in;
   logic [COLOR_BITS-1:0] o_color_ff, o_color_in;

   logic [RW-1:0]         dx, dy;
   logic [COORD_BITS-1:0] ax, ay, len;
   logic                  ge_x, ge_y;
   logic [RW-1:0]         diff_x, diff_y;
   logic [SW-1:0]         qx_ext, qy_ext;
   logic [PW-1:0]         rnd_x, rnd_y;

   // start: deltas and length
   always_comb begin
      dx  = {req_end_x[COORD_BITS-1], req_end_x} - {req_start_x[COORD_BITS-1], req_start_x};
      dy  = {req_end_y[COORD_BITS-1], req_end_y} - {req_start_y[COORD_BITS-1], req_start_y};
      ax  = dx[RW-1] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      ay  = dy[RW-1] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
      len = (ax >= ay) ? ax : ay;
   end

   // restoring divider, one quotient bit per axis per cycle; integer bit first
   always_comb begin
      ge_x   = rem_x_ff >= {1'b0, len_ff};
      ge_y   = rem_y_ff >= {1'b0, len_ff};
      diff_x = ge_x ? (rem_x_ff - {1'b0, len_ff}) : rem_x_ff;
      diff_y = ge_y ? (rem_y_ff - {1'b0, len_ff}) : rem_y_ff;
      qx_ext = {1'b0, quo_x_ff[QW-2:0], ge_x};
      qy_ext = {1'b0, quo_y_ff[QW-2:0], ge_y};
   end

   // round half away from zero: add half, less one for negatives, then floor
   always_comb begin
      rnd_x = pos_x_ff + HALF - PW'(pos_x_ff[PW-1]);
      rnd_y = pos_y_ff + HALF - PW'(pos_y_ff[PW-1]);
   end

   always_comb begin
      pos_x_in   = pos_x_ff;
      pos_y_in   = pos_y_ff;
      step_x_in  = step_x_ff;
      step_y_in  = step_y_ff;
      left_in    = left_ff;
      color_in   = color_ff;
      len_in     = len_ff;
      neg_x_in   = neg_x_ff;
      neg_y_in   = neg_y_ff;
      rem_x_in   = rem_x_ff;
      rem_y_in   = rem_y_ff;
      quo_x_in   = quo_x_ff;
      quo_y_in   = quo_y_ff;
      o_valid_in = o_valid_ff;
      o_last_in  = o_last_ff;
      o_x_in     = o_x_ff;
      o_y_in     = o_y_ff;
      o_len_in   = o_len_ff;
      o_color_in = o_color_ff;

      if (cmd.start) begin
         pos_x_in = {{2{req_start_x[COORD_BITS-1]}}, req_start_x, {FRAC_BITS{1'b0}}};
         pos_y_in = {{2{req_start_y[COORD_BITS-1]}}, req_start_y, {FRAC_BITS{1'b0}}};
         left_in  = len;
         color_in = req_line_color;
         len_in   = len;
         neg_x_in = dx[RW-1];
         neg_y_in = dy[RW-1];
         rem_x_in = {1'b0, ax};
         rem_y_in = {1'b0, ay};
         quo_x_in = '0;
         quo_y_in = '0;
      end

      if (cmd.div_run) begin
         rem_x_in = {diff_x[COORD_BITS-1:0], 1'b0};
         rem_y_in = {diff_y[COORD_BITS-1:0], 1'b0};
         quo_x_in = qx_ext[QW-1:0];
         quo_y_in = qy_ext[QW-1:0];
      end

      if (cmd.finish) begin
         // a zero-length line keeps zero increments
         if (len_ff == '0) begin
            step_x_in = '0;
            step_y_in = '0;
         end else begin
            step_x_in = neg_x_ff ? (-qx_ext) : qx_ext;
            step_y_in = neg_y_ff ? (-qy_ext) : qy_ext;
         end
         o_valid_in = 1'b0;
         o_last_in  = 1'b0;
         o_x_in     = '0;
         o_y_in     = '0;
         o_color_in = '0;
         o_len_in   = len_ff;
      end

      if (cmd.step) begin
         o_len_in = '0;
         if (left_ff == '0) begin
            o_valid_in = 1'b0;
            o_last_in  = 1'b0;
            o_x_in     = '0;
            o_y_in     = '0;
            o_color_in = '0;
         end else begin
            o_valid_in = 1'b1;
            o_last_in  = (left_ff == COORD_BITS'(1));
            o_x_in     = rnd_x[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
            o_y_in     = rnd_y[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
            o_color_in = color_ff;
            pos_x_in   = pos_x_ff + {{(PW-SW){step_x_ff[SW-1]}}, step_x_ff};
            pos_y_in   = pos_y_ff + {{(PW-SW){step_y_ff[SW-1]}}, step_y_ff};
            left_in    = left_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else begin
         left_ff <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_x_ff   <= pos_x_in;
      pos_y_ff   <= pos_y_in;
      step_x_ff  <= step_x_in;
      step_y_ff  <= step_y_in;
      color_ff   <= color_in;
      len_ff     <= len_in;
      neg_x_ff   <= neg_x_in;
      neg_y_ff   <= neg_y_in;
      rem_x_ff   <= rem_x_in;
      rem_y_ff   <= rem_y_in;
      quo_x_ff   <= quo_x_in;
      quo_y_ff   <= quo_y_in;
      o_valid_ff <= o_valid_in;
      o_last_ff  <= o_last_in;
      o_x_ff     <= o_x_in;
      o_y_ff     <= o_y_in;
      o_len_ff   <= o_len_in;
      o_color_ff <= o_color_in;
   end

   assign rsp_pixel_valid = o_valid_ff;
   assign rsp_pixel_x     = o_x_ff;
   assign rsp_pixel_y     = o_y_ff;
   assign rsp_pixel_color = o_color_ff;
   assign rsp_last_pixel  = o_last_ff;
   assign rsp_line_length = o_len_ff;

endmodule

// ----- src/dda_line_pixel_generator_core.sv -----
// DDA line rasterizer. A start request (func 0) latches two endpoints and a
// color, takes the line length as the larger absolute delta, and computes
// per-axis increments delta/length in signed fixed point with FRAC_BITS
// fraction bits, truncated toward zero. Each step request (func 1) returns
// the current position rounded half away from zero and then advances, for
// exactly length pixels (the end point itself is not drawn). Each step
// response is registered, and steps stream at one per cycle while the
// response side keeps up. A start request runs a restoring divider per
// axis (both in parallel, common length); its response is registered after
// the last iteration and no request is taken meanwhile.
module dda_line_pixel_generator_core #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 16
) (
   input logic          clock,
   input logic          reset,
   dlpg_req_if.sink     req_chan,
   dlpg_rsp_if.source   rsp_chan
);
   import dlpg_pkg::*;

   dlpg_cmd_type cmd;

   // sequencing: accept, divider iterations, response valid
   dlpg_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // line state, divider and the registered response payload
   dlpg_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_start_x     (req_chan.start_x),
      .req_start_y     (req_chan.start_y),
      .req_end_x       (req_chan.end_x),
      .req_end_y       (req_chan.end_y),
      .req_line_color  (req_chan.line_color),
      .rsp_pixel_valid (rsp_chan.pixel_valid),
      .rsp_pixel_x     (rsp_chan.pixel_x),
      .rsp_pixel_y     (rsp_chan.pixel_y),
      .rsp_pixel_color (rsp_chan.pixel_color),
      .rsp_last_pixel  (rsp_chan.last_pixel),
      .rsp_line_length (rsp_chan.line_length)
   );

endmodule

// ----- bench/tb_dda_line_pixel_generator_core.sv -----
`timescale 1ns / 100ps

module tb_dda_line_pixel_generator_core;
   import dlpg_pkg::*;

   localparam int     COORD_BITS  = 12;
   localparam int     FRAC_BITS   = 16;
   localparam longint FRAC_ONE    = longint'(1) << FRAC_BITS;
   localparam longint FRAC_HALF   = FRAC_ONE / 2;
   localparam int     COORD_MIN   = -(1 << (COORD_BITS - 1));
   localparam int     COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
   // start request: drain margin covering the divider run and its response
   localparam int     DRAIN_CYCLES = FRAC_BITS + 8;
   localparam int     RANDOM_REQS  = 1800;
   localparam int     DRAIN_POINT  = 900;   // sender waits for an empty pipe here
   localparam int     HOLD_POINT   = 400;   // receiver long hold-off starts here
   localparam int     HOLD_CYCLES  = 300;

   typedef struct packed {
      logic                          func;
      logic signed [COORD_BITS-1:0]  start_x;
      logic signed [COORD_BITS-1:0]  start_y;
      logic signed [COORD_BITS-1:0]  end_x;
      logic signed [COORD_BITS-1:0]  end_y;
      logic [COLOR_BITS-1:0]         line_color;
   } raster_req_type;

   typedef struct packed {
      logic                          pixel_valid;
      logic signed [COORD_BITS-1:0]  pixel_x;
      logic signed [COORD_BITS-1:0]  pixel_y;
      logic [COLOR_BITS-1:0]         pixel_color;
      logic                          last_pixel;
      logic [COORD_BITS-1:0]         line_length;
   } raster_rsp_type;

   // Line walker: mirrors the DDA state and keeps the responses still owed.
   class line_walker;
      longint          pos_x, pos_y;       // position, FRAC_BITS fraction bits
      longint          inc_x, inc_y;       // per-pixel increments
      int unsigned     pixels_left;
      logic [31:0]     held_color;
      raster_rsp_type  owed_rsp[$];
      int              errors;

      function new();
         pos_x = 0;
         pos_y = 0;
         inc_x = 0;
         inc_y = 0;
         pixels_left = 0;
         held_color = '0;
         errors = 0;
      endfunction

      // round half away from zero
      function longint round_coord(longint v);
         if (v >= 0) return (v + FRAC_HALF) / FRAC_ONE;
         return -((-v + FRAC_HALF) / FRAC_ONE);
      endfunction

      function void note_request(raster_req_type r);
         raster_rsp_type e;
         longint      sx, sy, dx, dy, ax, ay, len, rx, ry;
         e = '0;
         if (r.func == FUNC_START) begin
            sx = $signed(r.start_x);
            sy = $signed(r.start_y);
            dx = longint'($signed(r.end_x)) - sx;
            dy = longint'($signed(r.end_y)) - sy;
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            len = (ax >= ay) ? ax : ay;
            pos_x = sx * FRAC_ONE;
            pos_y = sy * FRAC_ONE;
            // longint division truncates toward zero
            inc_x = (len > 0) ? (dx * FRAC_ONE) / len : 0;
            inc_y = (len > 0) ? (dy * FRAC_ONE) / len : 0;
            pixels_left = int'(len);
            held_color = r.line_color;
            e.line_length = len[COORD_BITS-1:0];
         end else if (pixels_left != 0) begin
            rx = round_coord(pos_x);
            ry = round_coord(pos_y);
            e.pixel_valid = 1'b1;
            e.pixel_x = rx[COORD_BITS-1:0];
            e.pixel_y = ry[COORD_BITS-1:0];
            e.pixel_color = held_color;
            e.last_pixel = (pixels_left == 1);
            pos_x += inc_x;
            pos_y += inc_y;
            pixels_left--;
         end
         owed_rsp.push_back(e);
      endfunction

      function void compare_field(string fname, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            errors++;
         end
      endfunction

      function void check_response(raster_rsp_type got);
         raster_rsp_type want;
         if (owed_rsp.size() == 0) begin
            $display("%0t: response with none expected, expected none, actual %0h",
                     $time, got);
            errors++;
            return;
         end
         want = owed_rsp.pop_front();
         compare_field("pixel_valid", want.pixel_valid, got.pixel_valid);
         compare_field("pixel_x", want.pixel_x, got.pixel_x);
         compare_field("pixel_y", want.pixel_y, got.pixel_y);
         compare_field("pixel_color", want.pixel_color, got.pixel_color);
         compare_field("last_pixel", want.last_pixel, got.last_pixel);
         compare_field("line_length", want.line_length, got.line_length);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   dlpg_req_if #(.COORD_BITS(COORD_BITS)) req_chan ();
   dlpg_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_chan ();

   dda_line_pixel_generator_core #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   line_walker walker = new();
   int         requests_done = 0;   // accepted requests
   logic       burst_mode = 1'b0;   // sender: no gaps in this sequence
   logic       hold_rsp = 1'b0;     // receiver: long hold-off in progress

   always #1 clock = ~clock;

   // Gap before a request: mostly none or short, a few long.
   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function int rand_coord();
      return int'($urandom_range(0, (1 << COORD_BITS) - 1)) + COORD_MIN;
   endfunction

   function int clamp_coord(int v);
      if (v < COORD_MIN) return COORD_MIN;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   // Offer one request and hold it until the block takes it. Valid stays
   // high afterwards; the next gap (if any) lowers it, so a back-to-back
   // request never sees valid dropped and raised in the same time step.
   task automatic issue(input raster_req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.func       <= r.func;
      req_chan.start_x    <= r.start_x;
      req_chan.start_y    <= r.start_y;
      req_chan.end_x      <= r.end_x;
      req_chan.end_y      <= r.end_y;
      req_chan.line_color <= r.line_color;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      walker.note_request(r);
      requests_done++;
   endtask

   // Start request for a line, then a given number of step requests.
   // Step payloads are don't-care, so they carry random bits.
   task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                            input logic [31:0] color, input int n_steps);
      raster_req_type r;
      r.func       = FUNC_START;
      r.start_x    = sx[COORD_BITS-1:0];
      r.start_y    = sy[COORD_BITS-1:0];
      r.end_x      = ex[COORD_BITS-1:0];
      r.end_y      = ey[COORD_BITS-1:0];
      r.line_color = color;
      issue(r);
      repeat (n_steps) begin
         r.func       = FUNC_STEP;
         r.start_x    = COORD_BITS'($urandom);
         r.start_y    = COORD_BITS'($urandom);
         r.end_x      = COORD_BITS'($urandom);
         r.end_y      = COORD_BITS'($urandom);
         r.line_color = $urandom;
         issue(r);
      end
   endtask

   // Receiver: check every accepted response, then pick ready for the next
   // cycle. Stretches of always-ready alternate with random stalls.
   initial begin
      raster_rsp_type got;
      int          stall_left;
      int          mode_left;
      logic        steady;
      int          r;
      stall_left = 0;
      mode_left = 0;
      steady = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got.pixel_valid = rsp_chan.pixel_valid;
            got.pixel_x     = rsp_chan.pixel_x;
            got.pixel_y     = rsp_chan.pixel_y;
            got.pixel_color = rsp_chan.pixel_color;
            got.last_pixel  = rsp_chan.last_pixel;
            got.line_length = rsp_chan.line_length;
            walker.check_response(got);
         end
         if (mode_left == 0) begin
            steady = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(20, 150);
         end
         mode_left--;
         if (hold_rsp || stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            if (stall_left > 0) stall_left--;
         end else if (steady) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
               stall_left = $urandom_range(10, 40);
               rsp_chan.ready <= 1'b0;
            end else if (r < 30) begin
               stall_left = $urandom_range(0, 2);
               rsp_chan.ready <= 1'b0;
            end else begin
               rsp_chan.ready <= 1'b1;
            end
         end
      end
   end

   // Long receiver hold-off while the sender keeps going: the block's output
   // side fills and its request side has to stall.
   initial begin
      wait (requests_done >= HOLD_POINT);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Run limit, well above the slowest legal run.
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Stimulus
   initial begin
      raster_req_type r;
      int          sel, span, sx, sy, ex, ey, ax, ay, len, n_steps;
      logic        drained;
      drained = 1'b0;

      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.func      <= FUNC_STEP;
      req_chan.start_x   <= '0;
      req_chan.start_y   <= '0;
      req_chan.end_x     <= '0;
      req_chan.end_y     <= '0;
      req_chan.line_color <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed ---
      // step with no line active: empty response
      r = '0;
      r.func = FUNC_STEP;
      issue(r);
      // zero-length line, then a step that must find nothing to draw
      draw_line(0, 0, 0, 0, 32'hFFFF_FFFF, 1);
      // y increment of one half: rounds up to 1; one step past the end
      draw_line(0, 0, 2, 1, 32'hA5A5_A5A5, 3);
      // mirror image: minus one half rounds to -1
      draw_line(0, 0, -2, -1, 32'h5A5A_5A5A, 2);
      // full-range diagonal, abandoned mid-line by the next start
      draw_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 32'h0, 2);
      draw_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 32'h8000_0001, 2);
      // vertical, walked to the end exactly
      draw_line(5, -7, 5, -4, 32'h0123_4567, 3);
      // horizontal leftward, one step past the end
      draw_line(-3, 9, -6, 9, 32'hFEDC_BA98, 4);

      // --- random ---
      while (requests_done < RANDOM_REQS + 24) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         if (!drained && requests_done >= DRAIN_POINT) begin
            // sender pause until every response is back
            drained = 1'b1;
            req_chan.valid <= 1'b0;
            while (walker.owed_rsp.size() != 0) @(posedge clock);
         end
         sel = $urandom_range(0, 99);
         if (sel < 6) begin
            // noise: single request, anything goes
            r.func       = 1'($urandom_range(0, 1));
            r.start_x    = COORD_BITS'($urandom);
            r.start_y    = COORD_BITS'($urandom);
            r.end_x      = COORD_BITS'($urandom);
            r.end_y      = COORD_BITS'($urandom);
            r.line_color = $urandom;
            issue(r);
         end else if (sel < 12) begin
            // endpoints anywhere; only a few pixels of a long line
            draw_line(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                      $urandom, $urandom_range(0, 8));
         end else begin
            // short line anywhere, mostly walked to (or just past) its end
            span = ($urandom_range(0, 4) == 0) ? 200 : 12;
            sx = rand_coord();
            sy = rand_coord();
            ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
            ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
            ax = (ex > sx) ? ex - sx : sx - ex;
            ay = (ey > sy) ? ey - sy : sy - ey;
            len = (ax >= ay) ? ax : ay;
            if ($urandom_range(0, 4) == 0) n_steps = $urandom_range(0, len);
            else n_steps = len + $urandom_range(0, 2);
            draw_line(sx, sy, ex, ey, $urandom, n_steps);
         end
      end
      req_chan.valid <= 1'b0;

      // wait out the remaining responses, then a start request's latency
      while (walker.owed_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (walker.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
